// File: sv/sqmm_pkg.sv
package sqmm_pkg;

  localparam int DIM_MAX_DEF = 128;
  localparam int VAL_W = 24;
  localparam int DIST_W = 57;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_TRAIN = 3'd1;
  localparam logic [2:0] ACT_SEAL = 3'd2;
  localparam logic [2:0] ACT_ENCODE = 3'd3;
  localparam logic [2:0] ACT_DIST = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNTRAINED = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SEALED = 2'd3;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] REG_BITS = 3'd0;
  localparam logic [2:0] REG_DIM = 3'd4;

  localparam logic [VAL_W-1:0] V_MAX = 24'h7FFFFF;
  localparam logic [VAL_W-1:0] V_MIN = 24'h800000;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] dim_index;
    logic signed [23:0] sample_value;
    logic [7:0] stored_code;
    logic first_element;
    logic last_element;
  } req_t;

  typedef struct packed {
    logic [7:0] code_out;
    logic signed [23:0] reconstructed;
    logic [56:0] distance_sum;
    logic [1:0] status;
    logic last_out;
  } rsp_t;

  // Request to the shared divider.
  typedef struct packed {
    logic start;
    logic [32:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage

// File: sv/scalar_quantizer_min_max_unit.sv
// Scalar quantizer with per-dimension min/max ranges held in a synchronous
// memory. Items are handled one at a time. Clear, seal, train, unused actions
// and rejected requests go from acceptance through decode and then the output
// register (train writes its bounds back during decode). Encode runs a
// quantizing division, skipped when the value is at or below the low bound,
// and then a reconstruction division; a distance term runs the reconstruction
// division only and waits in the accumulate step for the square unless the
// difference is zero. Divisions use the bit-serial divider, with registered
// multiplies and square around it. A result sits in an output register, and
// the next request is taken in the cycle after it has been handed on.
module scalar_quantizer_min_max_unit #(
  parameter int DIM_MAX = sqmm_pkg::DIM_MAX_DEF,
  localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqmm_pkg::req_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sqmm_pkg::rsp_t     out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_Q_MUL = 4'd2;
  localparam logic [3:0] S_Q_DIV = 4'd3;
  localparam logic [3:0] S_Q_WAIT = 4'd4;
  localparam logic [3:0] S_D_MUL = 4'd5;
  localparam logic [3:0] S_D_DIV = 4'd6;
  localparam logic [3:0] S_D_WAIT = 4'd7;
  localparam logic [3:0] S_SQ = 4'd8;
  localparam logic [3:0] S_ACC = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0] bits_reg;
  logic [7:0] dim_reg;
  logic [3:0] state;
  sqmm_pkg::req_t req;
  logic trained;
  logic [56:0] run_dist;

  logic [3:0] bits_sat;
  logic [8:0] lm1;
  logic [8:0] dims;
  logic in_range;

  logic [23:0] low_r;
  logic [23:0] high_r;
  logic signed [24:0] span;
  logic [24:0] span_hold;
  logic signed [24:0] diff;
  logic [32:0] prod;
  logic [7:0] code;
  logic signed [25:0] recon_w;
  logic signed [23:0] recon;
  logic [24:0] absd;
  logic [49:0] sq;

  sqmm_pkg::div_req_t dreq;
  sqmm_pkg::div_rsp_t drsp;
  logic mem_wr;
  logic mem_clear;
  logic [23:0] new_low;
  logic [23:0] new_high;
  logic [57:0] acc_sum;
  logic [8:0] q_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_reg <= 4'd8;
      dim_reg <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        sqmm_pkg::REG_BITS: bits_reg <= pwdata[3:0];
        sqmm_pkg::REG_DIM: dim_reg <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      sqmm_pkg::REG_BITS: prdata = {28'd0, bits_reg};
      sqmm_pkg::REG_DIM: prdata = {24'd0, dim_reg};
      default: prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // Saturated configuration values.
  assign bits_sat = (bits_reg == 4'd0) ? 4'd1 : ((bits_reg > 4'd8) ? 4'd8 : bits_reg);
  assign lm1 = 9'((10'd1 << bits_sat) - 10'd1);
  always_comb begin
    if (dim_reg == 8'd0) dims = 9'd1;
    else if (32'(dim_reg) > DIM_MAX) dims = 9'(DIM_MAX);
    else dims = {1'b0, dim_reg};
  end
  assign in_range = {2'b0, req.dim_index} < 9'(dims);

  sqmm_range_mem #(.DIM_MAX(DIM_MAX)) u_mem (
    .clk(clk), .rst(rst), .clear(mem_clear),
    .rd_en(state == S_IDLE && in_valid && in_ready),
    .rd_addr(AW'(in_data.dim_index)),
    .wr_en(mem_wr), .wr_addr(AW'(req.dim_index)),
    .wr_low(new_low), .wr_high(new_high),
    .rd_low(low_r), .rd_high(high_r)
  );

  sqmm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Range arithmetic on the read bounds (held stable while the item runs).
  always_comb begin
    span = 25'($signed(high_r)) - 25'($signed(low_r));
    if (span < 25'sd1) span = 25'sd1;
    diff = 25'($signed(req.sample_value)) - 25'($signed(low_r));
    new_low = ($signed(req.sample_value) < $signed(low_r)) ? req.sample_value : low_r;
    new_high = ($signed(req.sample_value) > $signed(high_r)) ? req.sample_value : high_r;
    q_sat = (drsp.quotient > 33'(lm1)) ? lm1 : drsp.quotient[8:0];
    recon_w = 26'($signed(low_r)) + $signed({1'b0, drsp.quotient[24:0]});
  end

  assign mem_wr = state == S_READ && req.action == sqmm_pkg::ACT_TRAIN && in_range && !trained;
  assign mem_clear = state == S_READ && req.action == sqmm_pkg::ACT_CLEAR;
  assign in_ready = state == S_IDLE && !out_valid;
  assign acc_sum = (req.first_element ? 58'd0 : {1'b0, run_dist}) + {8'd0, sq};

  // Sequencer.
  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      trained <= 1'b0;
      run_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req <= in_data;
            state <= S_READ;
          end
        end
        S_READ: begin
          out_data.code_out <= '0;
          out_data.reconstructed <= '0;
          out_data.status <= sqmm_pkg::ST_OK;
          out_data.last_out <= req.last_element;
          code <= '0;
          state <= S_OUT;
          case (req.action)
            sqmm_pkg::ACT_CLEAR: trained <= 1'b0;
            sqmm_pkg::ACT_TRAIN: begin
              if (!in_range) out_data.status <= sqmm_pkg::ST_RANGE;
              else if (trained) out_data.status <= sqmm_pkg::ST_SEALED;
            end
            sqmm_pkg::ACT_SEAL: trained <= 1'b1;
            sqmm_pkg::ACT_ENCODE, sqmm_pkg::ACT_DIST: begin
              if (!trained) out_data.status <= sqmm_pkg::ST_UNTRAINED;
              else if (!in_range) out_data.status <= sqmm_pkg::ST_RANGE;
              else if (req.action == sqmm_pkg::ACT_ENCODE) begin
                if (diff > 25'sd0) state <= S_Q_MUL;
                else state <= S_D_MUL;
              end else begin
                code <= ({1'b0, req.stored_code} > lm1) ? lm1[7:0] : req.stored_code;
                state <= S_D_MUL;
              end
            end
            default: ;
          endcase
        end
        S_Q_MUL: begin
          prod <= 33'(diff[23:0]) * 33'(lm1);
          span_hold <= span;
          state <= S_Q_DIV;
        end
        S_Q_DIV: begin
          dreq.start <= 1'b1;
          dreq.dividend <= {diff[24] ? 1'b0 : prod[32], prod[31:0]};
          dreq.divisor <= span_hold;
          state <= S_Q_WAIT;
        end
        S_Q_WAIT: begin
          if (drsp.done) begin
            code <= q_sat[7:0];
            state <= S_D_MUL;
          end
        end
        S_D_MUL: begin
          prod <= 33'(code) * 33'(span);
          state <= S_D_DIV;
        end
        S_D_DIV: begin
          dreq.start <= 1'b1;
          dreq.dividend <= prod;
          dreq.divisor <= 25'(lm1);
          state <= S_D_WAIT;
        end
        S_D_WAIT: begin
          if (drsp.done) begin
            if (recon_w > 26'sd8388607) recon <= $signed(sqmm_pkg::V_MAX);
            else recon <= recon_w[23:0];
            state <= S_SQ;
          end
        end
        S_SQ: begin
          absd <= ($signed(req.sample_value) >= recon) ?
                  25'($signed(req.sample_value) - recon) :
                  25'(recon - $signed(req.sample_value));
          state <= S_ACC;
        end
        S_ACC: begin
          out_data.reconstructed <= recon;
          if (req.action == sqmm_pkg::ACT_ENCODE) begin
            out_data.code_out <= code;
            state <= S_OUT;
          end else if (sq != 50'd0 || absd == 25'd0) begin
            run_dist <= acc_sum[57] ? '1 : acc_sum[56:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_data.distance_sum <= run_dist;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Square register; loaded from the absolute difference in the accumulate step, cleared otherwise.
  always_ff @(posedge clk) begin
    if (state != S_ACC) sq <= '0;
    else sq <= 50'(absd) * 50'(absd);
  end

`ifndef NO_ASSERTIONS
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  a_out_after_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result out of sequence");
  a_wr_in_read: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> state == S_READ) else $error("range write outside read step");
`endif

endmodule

// File: sv/sqmm_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module sqmm_div (
  input  logic              clk,
  input  logic              rst,
  input  sqmm_pkg::div_req_t req,
  output sqmm_pkg::div_rsp_t rsp
);

  logic [32:0] quo;
  logic [25:0] rem;
  logic [24:0] dsr;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [25:0] trial;

  assign trial = {rem[24:0], quo[32]};

  // Load the operands on start; while busy, shift in one dividend bit and subtract where it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd33;
        quo <= req.dividend;
        rem <= '0;
        dsr <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= trial - {1'b0, dsr};
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quotient = quo;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy)) else $error("divider done without work");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("divider restarted while busy");
`endif

endmodule

// File: sv/sqmm_range_mem.sv
// Per-dimension low and high bounds, one synchronous memory each, with
// valid bits so that a clear only resets the valid bits, not the memories.
module sqmm_range_mem #(
  parameter int DIM_MAX = sqmm_pkg::DIM_MAX_DEF,
  localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_low,
  input  logic [23:0]   wr_high,
  output logic [23:0]   rd_low,
  output logic [23:0]   rd_high
);

  logic [23:0] low_mem [DIM_MAX];
  logic [23:0] high_mem [DIM_MAX];
  logic [DIM_MAX-1:0] valid;
  logic [23:0] low_q;
  logic [23:0] high_q;
  logic valid_q;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      low_mem[wr_addr] <= wr_low;
      high_mem[wr_addr] <= wr_high;
    end
    if (rd_en) begin
      low_q <= low_mem[rd_addr];
      high_q <= high_mem[rd_addr];
    end
  end

  // Valid bits and the read-side valid flag.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) valid[wr_addr] <= 1'b1;
      if (rd_en) valid_q <= valid[rd_addr];
    end
  end

  assign rd_low = valid_q ? low_q : sqmm_pkg::V_MAX;
  assign rd_high = valid_q ? high_q : sqmm_pkg::V_MIN;

`ifndef NO_ASSERTIONS
  a_no_rw_clear: assert property (@(posedge clk) disable iff (rst)
    clear |-> !wr_en) else $error("write during clear");
`endif

endmodule
